// ----- hw/rtl/utf8_stream_validator_macros.svh -----
// Assertion macros shared by the checker file of the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define USV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("usv assertion failed");

// Next-cycle implication, disabled while reset is high.
`define USV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("usv assertion failed");

`endif

// ----- hw/rtl/usv_pkg.sv -----
// Types and constants shared by the UTF-8 stream validator modules.
`default_nettype none

package usv_pkg;

  // Verdict codes given on the last byte of a string.
  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_INVALID   = 3'd2,
    VERDICT_OVERLONG  = 3'd3,
    VERDICT_CODEPOINT = 3'd4
  } verdict_t;

  // What a byte means when it arrives where a lead byte is expected.
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_STRAY_CONT,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_TOO_HIGH
  } lead_kind_t;

  // Lead bytes whose first continuation byte needs an extra range check.
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_E0,
    TAG_ED,
    TAG_F0
  } lead_tag_t;

  // Byte boundaries used by the classifier.
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_PATTERN = 8'h80;
  localparam logic [7:0] TWO_BASE     = 8'hC0;
  localparam logic [7:0] TWO_MIN_OK   = 8'hC2;
  localparam logic [7:0] THREE_BASE   = 8'hE0;
  localparam logic [7:0] FOUR_BASE    = 8'hF0;
  localparam logic [7:0] TOO_HIGH     = 8'hF8;
  localparam logic [7:0] SURR_LEAD    = 8'hED;
  localparam logic [7:0] CONT_A0      = 8'hA0;
  localparam logic [7:0] CONT_90      = 8'h90;

  // One classified byte, as it travels from the front to the back.
  typedef struct packed {
    logic       last;
    logic       is_cont;
    logic       below_90;
    logic       below_a0;
    lead_kind_t kind;
    logic       two_overlong;
    lead_tag_t  tag;
  } byte_class_t;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_stream_validator.sv -----
// Top level of the UTF-8 stream validator.
//
// Input channel: data_byte and end_of_string with byte_valid / byte_stall.
// A request is taken at a rising edge with byte_valid high and byte_stall
// low. Strings are sent back to back; end_of_string marks the last byte.
// Output channel: verdict with verdict_valid / verdict_stall. Exactly one
// verdict request is produced per string, on its last byte.
// Throughput is one byte per cycle while byte_stall is low. A byte lands in a
// two-entry queue at its accepting edge and is taken from the queue head by
// the sequence tracker, which registers the verdict when it pops a last byte.
// The queue lets bytes without an end mark keep flowing while a verdict
// waits. A last byte that meets a stalled verdict stays at the head of the
// queue; one more byte is taken behind it, and then byte_stall rises until
// the receiver takes the waiting verdict.
// Synchronous reset clears the queue, the tracker state and the output.
`default_nettype none

module utf8_stream_validator (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_string,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  output logic [2:0]      verdict,
  output logic            verdict_valid,
  input  wire logic       verdict_stall
);

  usv_pkg::byte_class_t front_item;
  usv_pkg::byte_class_t back_item;
  logic                 queue_full;
  logic                 queue_not_empty;
  logic                 back_pop;
  logic                 push;

  assign byte_stall = queue_full;
  assign push       = byte_valid && !queue_full;

  usv_front u_front (
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .item          (front_item)
  );

  usv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (back_pop),
    .pop_item  (back_item),
    .not_empty (queue_not_empty)
  );

  usv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (queue_not_empty),
    .item          (back_item),
    .pop           (back_pop),
    .verdict       (verdict),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/usv_front.sv -----
// Front end: classifies each incoming byte for the sequence tracker.
`default_nettype none

module usv_front (
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_string,
  output usv_pkg::byte_class_t    item
);

  // Decode the byte both as a possible lead and as a possible continuation.
  always_comb begin
    item.last         = end_of_string;
    item.is_cont      = (data_byte & usv_pkg::CONT_MASK) == usv_pkg::CONT_PATTERN;
    item.below_90     = data_byte < usv_pkg::CONT_90;
    item.below_a0     = data_byte < usv_pkg::CONT_A0;
    item.two_overlong = data_byte < usv_pkg::TWO_MIN_OK;

    if (data_byte < usv_pkg::CONT_PATTERN) begin
      item.kind = usv_pkg::LEAD_ASCII;
    end else if (data_byte < usv_pkg::TWO_BASE) begin
      item.kind = usv_pkg::LEAD_STRAY_CONT;
    end else if (data_byte < usv_pkg::THREE_BASE) begin
      item.kind = usv_pkg::LEAD_TWO;
    end else if (data_byte < usv_pkg::FOUR_BASE) begin
      item.kind = usv_pkg::LEAD_THREE;
    end else if (data_byte < usv_pkg::TOO_HIGH) begin
      item.kind = usv_pkg::LEAD_FOUR;
    end else begin
      item.kind = usv_pkg::LEAD_TOO_HIGH;
    end

    if (data_byte == usv_pkg::THREE_BASE) begin
      item.tag = usv_pkg::TAG_E0;
    end else if (data_byte == usv_pkg::SURR_LEAD) begin
      item.tag = usv_pkg::TAG_ED;
    end else if (data_byte == usv_pkg::FOUR_BASE) begin
      item.tag = usv_pkg::TAG_F0;
    end else begin
      item.tag = usv_pkg::TAG_NONE;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/usv_queue.sv -----
// Two-entry queue of classified bytes between the front and the back.
`default_nettype none

module usv_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire usv_pkg::byte_class_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output usv_pkg::byte_class_t      pop_item,
  output logic                      not_empty
);

  usv_pkg::byte_class_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item  = slots[rd_ptr];

  // Storage is written without reset; only the pointers and the fill count are cleared.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/usv_back.sv -----
// Back end: tracks open sequences, records the first error, emits the verdict.
`default_nettype none

module usv_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire usv_pkg::byte_class_t item,
  output logic                      pop,
  output logic [2:0]                verdict,
  output logic                      verdict_valid,
  input  wire logic                 verdict_stall
);

  usv_pkg::verdict_t  first_error;
  usv_pkg::verdict_t  first_error_next;
  logic [1:0]         bytes_due;
  logic [1:0]         bytes_due_next;
  logic               first_cont;
  logic               first_cont_next;
  usv_pkg::lead_tag_t lead_tag;
  usv_pkg::lead_tag_t lead_tag_next;
  usv_pkg::verdict_t  seq_error;
  usv_pkg::verdict_t  seq_error_next;
  usv_pkg::verdict_t  result;
  logic               out_free;

  // The output register can take a new verdict when empty or being drained.
  assign out_free = !verdict_valid || !verdict_stall;
  assign pop      = item_valid && (!item.last || out_free);

  // Per-byte state update.
  always_comb begin
    first_error_next = first_error;
    bytes_due_next   = bytes_due;
    first_cont_next  = first_cont;
    lead_tag_next    = lead_tag;
    seq_error_next   = seq_error;

    if (bytes_due == 2'd0) begin
      case (item.kind)
        usv_pkg::LEAD_ASCII: begin
        end
        usv_pkg::LEAD_STRAY_CONT: begin
          if (first_error == usv_pkg::VERDICT_OK) begin
            first_error_next = usv_pkg::VERDICT_INVALID;
          end
        end
        usv_pkg::LEAD_TWO: begin
          bytes_due_next  = 2'd1;
          first_cont_next = 1'b1;
          lead_tag_next   = item.tag;
          seq_error_next  = item.two_overlong ? usv_pkg::VERDICT_OVERLONG
                                              : usv_pkg::VERDICT_OK;
        end
        usv_pkg::LEAD_THREE: begin
          bytes_due_next  = 2'd2;
          first_cont_next = 1'b1;
          lead_tag_next   = item.tag;
          seq_error_next  = usv_pkg::VERDICT_OK;
        end
        usv_pkg::LEAD_FOUR: begin
          bytes_due_next  = 2'd3;
          first_cont_next = 1'b1;
          lead_tag_next   = item.tag;
          seq_error_next  = usv_pkg::VERDICT_OK;
        end
        default: begin
          if (first_error == usv_pkg::VERDICT_OK) begin
            first_error_next = usv_pkg::VERDICT_CODEPOINT;
          end
        end
      endcase
    end else begin
      // Continuation byte: a bad one beats any range error of the sequence.
      if (!item.is_cont) begin
        seq_error_next = usv_pkg::VERDICT_INVALID;
      end else if (first_cont && seq_error == usv_pkg::VERDICT_OK) begin
        if (lead_tag == usv_pkg::TAG_E0 && item.below_a0) begin
          seq_error_next = usv_pkg::VERDICT_OVERLONG;
        end else if (lead_tag == usv_pkg::TAG_ED && !item.below_a0) begin
          seq_error_next = usv_pkg::VERDICT_CODEPOINT;
        end else if (lead_tag == usv_pkg::TAG_F0 && item.below_90) begin
          seq_error_next = usv_pkg::VERDICT_OVERLONG;
        end
      end
      first_cont_next = 1'b0;
      bytes_due_next  = bytes_due - 2'd1;
      // A finished sequence commits its pending error.
      if (bytes_due_next == 2'd0) begin
        if (first_error == usv_pkg::VERDICT_OK) begin
          first_error_next = seq_error_next;
        end
        seq_error_next = usv_pkg::VERDICT_OK;
      end
    end

    // Verdict for a string that ends on this byte.
    if (first_error_next != usv_pkg::VERDICT_OK) begin
      result = first_error_next;
    end else if (bytes_due_next != 2'd0) begin
      result = usv_pkg::VERDICT_SHORT;
    end else begin
      result = usv_pkg::VERDICT_OK;
    end
  end

  // State registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_error   <= usv_pkg::VERDICT_OK;
      bytes_due     <= 2'd0;
      first_cont    <= 1'b0;
      lead_tag      <= usv_pkg::TAG_NONE;
      seq_error     <= usv_pkg::VERDICT_OK;
      verdict_valid <= 1'b0;
      verdict       <= usv_pkg::VERDICT_OK;
    end else begin
      if (pop) begin
        if (item.last) begin
          first_error <= usv_pkg::VERDICT_OK;
          bytes_due   <= 2'd0;
          first_cont  <= 1'b0;
          lead_tag    <= usv_pkg::TAG_NONE;
          seq_error   <= usv_pkg::VERDICT_OK;
        end else begin
          first_error <= first_error_next;
          bytes_due   <= bytes_due_next;
          first_cont  <= first_cont_next;
          lead_tag    <= lead_tag_next;
          seq_error   <= seq_error_next;
        end
      end
      if (pop && item.last) begin
        verdict_valid <= 1'b1;
        verdict       <= result;
      end else if (out_free) begin
        verdict_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/usv_checker.sv -----
// Port-level checker for the UTF-8 stream validator, bound to the top level.
`default_nettype none
`include "utf8_stream_validator_macros.svh"

module usv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       byte_stall,
  input wire logic [2:0] verdict,
  input wire logic       verdict_valid,
  input wire logic       verdict_stall
);

  // A verdict never carries a code outside the defined set.
  `USV_ASSERT_IMPLY(a_verdict_range, clk, rst, verdict_valid, verdict <= 3'd4)

  // No verdict is pending right after reset is released.
  `USV_ASSERT_IMPLY(a_clear_after_reset, clk, rst, $past(rst), !verdict_valid)

  // The input only backs up behind a verdict that is still waiting.
  `USV_ASSERT_IMPLY(a_stall_needs_verdict, clk, rst, byte_stall, verdict_valid)

  // A stalled verdict holds until it is taken.
  `USV_ASSERT_NEXT(a_verdict_hold, clk, rst, verdict_valid && verdict_stall,
                   verdict_valid && verdict == $past(verdict))

endmodule

bind utf8_stream_validator usv_checker u_usv_checker (
  .clk           (clk),
  .rst           (rst),
  .byte_stall    (byte_stall),
  .verdict       (verdict),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall)
);

`default_nettype wire

// ----- tb/utf8_stream_validator_tb.sv -----
// Self-checking testbench for the UTF-8 stream validator.
module utf8_stream_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usv_pkg::*;

  localparam int RANDOM_BYTES = 1100;
  localparam int QUIET_TAIL   = 120;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int DEAD_LIMIT   = 1000;

  // One pending input request; drain_first makes the sender wait for all verdicts.
  typedef struct {
    logic [7:0] data;
    logic       eos;
    bit         drain_first;
  } byte_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [2:0] verdict;
  logic       verdict_valid;
  logic       verdict_stall = 1'b0;

  byte_req_t  pending_bytes[$];
  verdict_t   verdicts_due[$];

  logic       byte_taken = 1'b0;
  int         bytes_taken_cnt = 0;
  int         dead_cycles = 0;
  int         error_cnt = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // Tracker state of the expected behavior.
  verdict_t   str_error = VERDICT_OK;
  verdict_t   seq_error = VERDICT_OK;
  logic [1:0] cont_due = 2'd0;
  logic [7:0] open_lead = 8'h00;

  utf8_stream_validator i_dut (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .verdict       (verdict),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Only the first error of a string is kept.
  function automatic void note_error(verdict_t e);
    if (e != VERDICT_OK && str_error == VERDICT_OK) begin
      str_error = e;
    end
  endfunction

  // Advance the expected tracker by one byte and queue a verdict on the last byte.
  function automatic void track_byte(logic [7:0] b, logic eos);
    logic [1:0] seq_len;
    bit         is_first;
    if (cont_due == 2'd0) begin
      if (b < CONT_PATTERN) begin
        // Plain ASCII leaves the state alone.
      end else if (b < TWO_BASE) begin
        note_error(VERDICT_INVALID);
      end else if (b < THREE_BASE) begin
        open_lead = b;
        cont_due  = 2'd1;
        seq_error = (b < TWO_MIN_OK) ? VERDICT_OVERLONG : VERDICT_OK;
      end else if (b < FOUR_BASE) begin
        open_lead = b;
        cont_due  = 2'd2;
        seq_error = VERDICT_OK;
      end else if (b < TOO_HIGH) begin
        open_lead = b;
        cont_due  = 2'd3;
        seq_error = VERDICT_OK;
      end else begin
        note_error(VERDICT_CODEPOINT);
      end
    end else begin
      seq_len  = (open_lead < THREE_BASE) ? 2'd1 : (open_lead < FOUR_BASE) ? 2'd2 : 2'd3;
      is_first = (cont_due == seq_len);
      if ((b & CONT_MASK) != CONT_PATTERN) begin
        seq_error = VERDICT_INVALID;
      end else if (is_first && seq_error == VERDICT_OK) begin
        if (open_lead == THREE_BASE && b < CONT_A0) begin
          seq_error = VERDICT_OVERLONG;
        end else if (open_lead == SURR_LEAD && b >= CONT_A0) begin
          seq_error = VERDICT_CODEPOINT;
        end else if (open_lead == FOUR_BASE && b < CONT_90) begin
          seq_error = VERDICT_OVERLONG;
        end
      end
      cont_due = cont_due - 2'd1;
      if (cont_due == 2'd0) begin
        note_error(seq_error);
        seq_error = VERDICT_OK;
      end
    end
    if (eos) begin
      if (str_error != VERDICT_OK) begin
        verdicts_due.push_back(str_error);
      end else if (cont_due != 2'd0) begin
        verdicts_due.push_back(VERDICT_SHORT);
      end else begin
        verdicts_due.push_back(VERDICT_OK);
      end
      str_error = VERDICT_OK;
      seq_error = VERDICT_OK;
      cont_due  = 2'd0;
      open_lead = 8'h00;
    end
  endfunction

  // Idling is off in every fourth stretch of 128 bytes and near the end.
  function automatic bit idling_on();
    return (pending_bytes.size() > QUIET_TAIL) && ((bytes_taken_cnt / 128) % 4 != 3);
  endfunction

  // Queue one byte for the sender.
  task automatic put(logic [7:0] b, logic eos, bit drain = 1'b0);
    byte_req_t r;
    r.data        = b;
    r.eos         = eos;
    r.drain_first = drain;
    pending_bytes.push_back(r);
  endtask

  // Append one character, well formed or with loosened rules and damage.
  task automatic append_char(ref logic [7:0] s[$], input bit loose);
    logic [7:0] enc[4];
    int         nb;
    int         keep;
    int         k;
    nb = $urandom_range(1, 4);
    for (k = 1; k < 4; k++) enc[k] = 8'h80 | 8'($urandom_range(0, 63));
    case (nb)
      1: begin
        enc[0] = 8'($urandom_range(0, 127));
      end
      2: begin
        enc[0] = loose ? 8'($urandom_range(8'hC0, 8'hDF)) : 8'($urandom_range(8'hC2, 8'hDF));
      end
      3: begin
        if (loose && $urandom_range(0, 2) == 0) begin
          enc[0] = $urandom_range(0, 1) ? THREE_BASE : SURR_LEAD;
        end else begin
          enc[0] = 8'($urandom_range(8'hE0, 8'hEF));
        end
      end
      default: begin
        if (loose && $urandom_range(0, 2) == 0) begin
          enc[0] = FOUR_BASE;
        end else begin
          enc[0] = 8'($urandom_range(8'hF0, 8'hF7));
        end
      end
    endcase
    // Well-formed text keeps the first continuation in its legal range.
    if (!loose) begin
      if (enc[0] == THREE_BASE) enc[1] = 8'($urandom_range(8'hA0, 8'hBF));
      if (enc[0] == SURR_LEAD) enc[1] = 8'($urandom_range(8'h80, 8'h9F));
      if (enc[0] == FOUR_BASE) enc[1] = 8'($urandom_range(8'h90, 8'hBF));
    end
    keep = nb;
    if (loose && $urandom_range(0, 3) == 0) enc[$urandom_range(0, nb - 1)] = 8'($urandom);
    if (loose && nb > 1 && $urandom_range(0, 3) == 0) keep = $urandom_range(1, nb - 1);
    for (k = 0; k < keep; k++) s.push_back(enc[k]);
  endtask

  // Build one random string and queue it.
  task automatic add_random_string(bit drain);
    logic [7:0] s[$];
    int         kind;
    int         n;
    int         k;
    kind = $urandom_range(0, 9);
    n    = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      if (kind >= 8) s.push_back(8'($urandom));
      else append_char(s, kind >= 6);
    end
    for (k = 0; k < s.size(); k++) put(s[k], k == s.size() - 1, drain && k == 0);
  endtask

  // Sender: presents the next request once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      send_gap = 0;
    end else if (!byte_valid || byte_taken) begin
      if (send_gap > 0) begin
        byte_valid <= 1'b0;
        send_gap--;
      end else if (pending_bytes.size() == 0) begin
        byte_valid <= 1'b0;
      end else if (pending_bytes[0].drain_first && verdicts_due.size() != 0) begin
        byte_valid <= 1'b0;
      end else if (idling_on() && hold_left == 0 && $urandom_range(0, 7) == 0) begin
        byte_valid <= 1'b0;
        send_gap = $urandom_range(1, 7) - 1;
      end else begin
        data_byte     <= pending_bytes[0].data;
        end_of_string <= pending_bytes[0].eos;
        byte_valid    <= 1'b1;
        void'(pending_bytes.pop_front());
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      verdict_stall <= 1'b0;
    end else if (hold_left > 0) begin
      verdict_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && bytes_taken_cnt >= HOLD_AT) begin
      verdict_stall <= 1'b1;
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
    end else if (stall_left > 0) begin
      verdict_stall <= 1'b1;
      stall_left--;
    end else if (idling_on() && $urandom_range(0, 5) == 0) begin
      verdict_stall <= 1'b1;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      verdict_stall <= 1'b0;
    end
  end

  // Monitor: predicts on accepted requests and checks accepted verdicts.
  always @(posedge clk) begin
    if (rst) begin
      byte_taken  <= 1'b0;
      dead_cycles <= 0;
    end else begin
      byte_taken <= byte_valid && !byte_stall;
      if (byte_valid && !byte_stall) begin
        track_byte(data_byte, end_of_string);
        bytes_taken_cnt <= bytes_taken_cnt + 1;
      end
      if (verdict_valid && !verdict_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict: expected none, got %0d", verdict);
          error_cnt++;
        end else begin
          if (verdict !== verdicts_due[0]) begin
            $error("verdict: expected %0d, got %0d", verdicts_due[0], verdict);
            error_cnt++;
          end
          void'(verdicts_due.pop_front());
        end
      end
      if ((byte_valid && !byte_stall) || (verdict_valid && !verdict_stall)) dead_cycles <= 0;
      else dead_cycles <= dead_cycles + 1;
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    while (dead_cycles < DEAD_LIMIT) @(negedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int strings;
    // Directed strings: field extremes and every special case.
    put(8'h00, 1'b1);
    put(8'hFF, 1'b1);
    put(8'h80, 1'b1);
    put(8'hBF, 1'b1);
    put(8'hC1, 1'b0); put(8'hBF, 1'b1);
    put(8'hDF, 1'b0); put(8'hBF, 1'b1);
    put(8'hE0, 1'b0); put(8'h9F, 1'b0); put(8'hBF, 1'b1);
    put(8'hED, 1'b0); put(8'hA0, 1'b0); put(8'h80, 1'b1);
    put(8'hF0, 1'b0); put(8'h8F, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b1);
    put(8'hF7, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b1);
    put(8'hC2, 1'b0); put(8'h7F, 1'b1);
    // String ends inside a sequence that already holds an overlong error.
    put(8'hE0, 1'b0); put(8'h80, 1'b1);

    strings = 0;
    while (pending_bytes.size() < RANDOM_BYTES) begin
      add_random_string(strings == 40 || strings == 90);
      strings++;
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || byte_valid || verdicts_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/usv_pkg.sv
hw/rtl/usv_front.sv
hw/rtl/usv_queue.sv
hw/rtl/usv_back.sv
hw/rtl/utf8_stream_validator.sv
hw/rtl/usv_checker.sv
tb/utf8_stream_validator_tb.sv
